### design/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants of the cluster centroid accumulator
// Word layouts of the item and result channels, the divider handshake and
// the fixed widths of the weighted-mean datapath.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam logic [5:0] FIRST_LAYER_INIT = 6'd52;

	localparam int NUM_W = 37;
	localparam int DEN_W = 21;
	localparam int QUO_W = 16;

	typedef struct packed {
		logic               start_new;
		logic [31:0]        item_id;
		logic [15:0]        item_pt;
		logic [19:0]        item_energy;
		logic signed [11:0] item_eta;
		logic signed [11:0] item_phi;
		logic signed [15:0] item_z;
		logic signed [15:0] item_xnorm;
		logic signed [15:0] item_ynorm;
		logic [5:0]         item_layer;
		logic [6:0]         item_cells;
	} item_t;

	typedef struct packed {
		logic [31:0]        cluster_id;
		logic [19:0]        pt_sum;
		logic [23:0]        energy_sum;
		logic signed [11:0] centre_eta;
		logic signed [11:0] centre_phi;
		logic signed [15:0] centre_z;
		logic signed [15:0] mean_xnorm;
		logic signed [15:0] mean_ynorm;
		logic [5:0]         first_layer;
		logic [5:0]         last_layer;
		logic [5:0]         shower_length;
		logic [15:0]        cell_total;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

endpackage

### design/cluster_centroid_accumulator.sv
// ----------------------------------------------------------------------------
// cluster_centroid_accumulator: 3D cluster builder
// Merges a stream of constituents into one cluster and reports the cluster
// after every constituent.
// ----------------------------------------------------------------------------
// Each word on the item channel is one constituent; a word with start_new set
// first clears the cluster and takes the constituent id. For every item one
// result word carries the whole cluster state after the merge.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. Sums, layers and the x/y average are updated in the accept
// cycle. Eta, phi and z then go one after the other through one shared
// multiplier (two products, then a sum) and one serial divider that yields
// a quotient bit per cycle. When the pt sum is zero the divisions are skipped.
// item_stall stays high until the result is loaded into the output register,
// so no new item is taken before the last one is through. The result sits
// in an output register, so the next item is accepted while a result waits;
// a stalled receiver only holds the block once the following result is
// ready. After reset the cluster is empty, first layer 52, and no result is
// pending.
// ----------------------------------------------------------------------------
module cluster_centroid_accumulator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  cca_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output cca_pkg::result_t result
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL_A = 3'd1;
	localparam logic [2:0] S_MUL_B = 3'd2;
	localparam logic [2:0] S_SUM   = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [1:0] K_ETA = 2'd0;
	localparam logic [1:0] K_PHI = 2'd1;
	localparam logic [1:0] K_Z   = 2'd2;

	logic [2:0]         state_q;
	logic [1:0]         k_q;
	cca_pkg::item_t     item_q;
	logic [19:0]        w_q;
	logic [20:0]        d_q;
	logic               neg_q;
	logic signed [37:0] prod_q;
	logic signed [37:0] acc_q;

	logic [31:0]        id_q;
	logic [19:0]        pt_acc_q;
	logic [23:0]        energy_acc_q;
	logic signed [11:0] eta_q;
	logic signed [11:0] phi_q;
	logic signed [15:0] z_q;
	logic signed [15:0] xnorm_q;
	logic signed [15:0] ynorm_q;
	logic [5:0]         first_q;
	logic [5:0]         last_q;
	logic [5:0]         length_q;
	logic [15:0]        cells_q;

	cca_pkg::result_t   out_q;
	logic               out_valid_q;

	cca_pkg::div_req_t  div_req;
	cca_pkg::div_rsp_t  div_rsp;

	logic               accept;
	logic               out_take;
	logic               out_load;

	logic [19:0]        b_pt;
	logic [23:0]        b_energy;
	logic [15:0]        b_cells;
	logic [5:0]         b_first;
	logic [5:0]         b_last;
	logic [5:0]         n_first;
	logic [20:0]        pt_sum_c;
	logic [24:0]        en_sum_c;
	logic [16:0]        cell_sum_c;
	logic [16:0]        xs_c;
	logic [16:0]        ys_c;
	logic [20:0]        d_c;

	logic signed [16:0] vin_c;
	logic signed [16:0] v_c;
	logic signed [16:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [37:0] prod_c;
	logic signed [38:0] n_c;
	logic [38:0]        mag_c;
	logic signed [16:0] q_c;
	logic signed [16:0] q_clamp;

	assign accept   = item_valid && !item_stall;
	assign out_take = out_valid_q && !result_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !result_stall);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		b_pt     = item.start_new ? 20'd0 : pt_acc_q;
		b_energy = item.start_new ? 24'd0 : energy_acc_q;
		b_cells  = item.start_new ? 16'd0 : cells_q;
		b_first  = item.start_new ? cca_pkg::FIRST_LAYER_INIT : first_q;
		b_last   = item.start_new ? 6'd0 : last_q;
		n_first  = (item.item_layer < b_first) ? item.item_layer : b_first;
		pt_sum_c   = {1'b0, b_pt} + {5'd0, item.item_pt};
		en_sum_c   = {1'b0, b_energy} + {5'd0, item.item_energy};
		cell_sum_c = {1'b0, b_cells} + {10'd0, item.item_cells};
		xs_c = {xnorm_q[15], xnorm_q} + {item.item_xnorm[15], item.item_xnorm};
		ys_c = {ynorm_q[15], ynorm_q} + {item.item_ynorm[15], item.item_ynorm};
		d_c  = {5'd0, item.item_pt} + {1'b0, b_pt};
	end

	always_comb begin
		case (k_q)
			K_ETA: begin
				vin_c = 17'(item_q.item_eta);
				v_c   = 17'(eta_q);
			end
			K_PHI: begin
				vin_c = 17'(item_q.item_phi);
				v_c   = 17'(phi_q);
			end
			default: begin
				vin_c = 17'(item_q.item_z);
				v_c   = 17'(z_q);
			end
		endcase
		mul_a  = (state_q == S_MUL_A) ? vin_c : v_c;
		mul_b  = (state_q == S_MUL_A) ? $signed({5'd0, item_q.item_pt})
		                              : $signed({1'b0, w_q});
		prod_c = 38'(mul_a) * 38'(mul_b);
		n_c    = 39'(acc_q) + 39'(prod_q);
		mag_c  = n_c[38] ? 39'(-n_c) : 39'(n_c);
		div_req.start = (state_q == S_SUM);
		div_req.num   = mag_c[36:0] + {17'd0, d_q[20:1]};
		div_req.den   = d_q;
		q_c = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
		if (k_q == K_Z) begin
			if (q_c > 17'sd32767) begin
				q_clamp = 17'sd32767;
			end else if (q_c < -17'sd32768) begin
				q_clamp = -17'sd32768;
			end else begin
				q_clamp = q_c;
			end
		end else begin
			if (q_c > 17'sd2047) begin
				q_clamp = 17'sd2047;
			end else if (q_c < -17'sd2048) begin
				q_clamp = -17'sd2048;
			end else begin
				q_clamp = q_c;
			end
		end
	end

	cca_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= K_ETA;
			out_valid_q  <= 1'b0;
			id_q         <= 32'd0;
			pt_acc_q     <= 20'd0;
			energy_acc_q <= 24'd0;
			eta_q        <= 12'sd0;
			phi_q        <= 12'sd0;
			z_q          <= 16'sd0;
			xnorm_q      <= 16'sd0;
			ynorm_q      <= 16'sd0;
			first_q      <= cca_pkg::FIRST_LAYER_INIT;
			last_q       <= 6'd0;
			length_q     <= 6'd0;
			cells_q      <= 16'd0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q <= K_ETA;
						if (item.start_new) begin
							id_q    <= item.item_id;
							eta_q   <= item.item_eta;
							phi_q   <= item.item_phi;
							z_q     <= item.item_z;
							xnorm_q <= item.item_xnorm;
							ynorm_q <= item.item_ynorm;
						end else begin
							xnorm_q <= xs_c[16:1];
							ynorm_q <= ys_c[16:1];
						end
						pt_acc_q     <= pt_sum_c[20] ? 20'hFFFFF : pt_sum_c[19:0];
						energy_acc_q <= en_sum_c[24] ? 24'hFFFFFF : en_sum_c[23:0];
						cells_q      <= cell_sum_c[16] ? 16'hFFFF : cell_sum_c[15:0];
						first_q      <= n_first;
						if (item.item_layer > b_last) begin
							last_q   <= item.item_layer;
							length_q <= item.item_layer - n_first;
						end else begin
							last_q   <= b_last;
							length_q <= item.start_new ? 6'd0 : length_q;
						end
						state_q <= (d_c == 21'd0) ? S_DONE : S_MUL_A;
					end
				end
				S_MUL_A: begin
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						case (k_q)
							K_ETA: eta_q <= q_clamp[11:0];
							K_PHI: phi_q <= q_clamp[11:0];
							default: z_q <= q_clamp[15:0];
						endcase
						if (k_q == K_Z) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_MUL_A;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			w_q    <= b_pt;
			d_q    <= d_c;
		end
		if (state_q == S_MUL_A || state_q == S_MUL_B) begin
			prod_q <= prod_c;
		end
		if (state_q == S_MUL_B) begin
			acc_q <= prod_q;
		end
		if (state_q == S_SUM) begin
			neg_q <= n_c[38];
		end
		if (out_load) begin
			out_q.cluster_id    <= id_q;
			out_q.pt_sum        <= pt_acc_q;
			out_q.energy_sum    <= energy_acc_q;
			out_q.centre_eta    <= eta_q;
			out_q.centre_phi    <= phi_q;
			out_q.centre_z      <= z_q;
			out_q.mean_xnorm    <= xnorm_q;
			out_q.mean_ynorm    <= ynorm_q;
			out_q.first_layer   <= first_q;
			out_q.last_layer    <= last_q;
			out_q.shower_length <= length_q;
			out_q.cell_total    <= cells_q;
		end
	end

endmodule

### design/cca_divider.sv
// ----------------------------------------------------------------------------
// cca_divider: serial restoring divider
// Divides an unsigned numerator by an unsigned denominator, one quotient bit
// per cycle. The quotient must be known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module cca_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cca_pkg::div_req_t req,
	output cca_pkg::div_rsp_t rsp
);

	logic [cca_pkg::DEN_W-1:0] rem_q;
	logic [cca_pkg::QUO_W-1:0] lo_q;
	logic [cca_pkg::DEN_W-1:0] den_q;
	logic [3:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [cca_pkg::DEN_W:0]   trial;
	logic [cca_pkg::DEN_W:0]   diff;
	logic                      ge;

	always_comb begin
		trial = {rem_q, lo_q[cca_pkg::QUO_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[cca_pkg::NUM_W-1:cca_pkg::QUO_W];
			lo_q  <= req.num[cca_pkg::QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[cca_pkg::DEN_W-1:0] : trial[cca_pkg::DEN_W-1:0];
			lo_q  <= {lo_q[cca_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = lo_q;

endmodule
